FILE: design/ted_pkg.sv
// Shared types and constants for the text encoding detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package ted_pkg;

  // Result codes
  typedef enum logic [2:0] {
    ENC_UNKNOWN  = 3'd0,
    ENC_UTF8_BOM = 3'd1,
    ENC_UTF32LE  = 3'd2,
    ENC_UTF32BE  = 3'd3,
    ENC_UTF16LE  = 3'd4,
    ENC_UTF16BE  = 3'd5,
    ENC_UTF8     = 3'd6,
    ENC_SJIS     = 3'd7
  } enc_t;

  // Allowed range of the next UTF-8 continuation byte
  typedef enum logic [2:0] {
    U8C_ANY  = 3'd0,  // 80-BF
    U8C_A0BF = 3'd1,
    U8C_809F = 3'd2,
    U8C_90BF = 3'd3,
    U8C_808F = 3'd4
  } u8_class_t;

  localparam int HeadDepth = 4;

  // Byte-order marks
  localparam logic [7:0] BomUtf8B0 = 8'hEF;
  localparam logic [7:0] BomUtf8B1 = 8'hBB;
  localparam logic [7:0] BomUtf8B2 = 8'hBF;
  localparam logic [7:0] BomFF     = 8'hFF;
  localparam logic [7:0] BomFE     = 8'hFE;
  localparam logic [7:0] BomZero   = 8'h00;

  function automatic logic in_range(input logic [7:0] b, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

`default_nettype wire

FILE: design/ted_head.sv
// Holds the first four bytes of a buffer and matches byte-order marks.
// Depends on ted_pkg.
`default_nettype none

module ted_head (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,      // item processed this cycle
  input  wire logic             take,      // item carries a byte
  input  wire logic             clear,     // item ends the buffer
  input  wire logic [7:0]       data_byte,
  output ted_pkg::enc_t         bom_next,  // mark code including this byte
  output logic                  nonempty_next
);
  import ted_pkg::*;

  logic [7:0] head_bytes [HeadDepth];
  logic [7:0] head_bytes_next [HeadDepth];
  logic [2:0] head_count;
  logic [2:0] head_count_next;

  always_comb begin
    head_bytes_next = head_bytes;
    head_count_next = head_count;
    if (take && (head_count < 3'(HeadDepth))) begin
      head_bytes_next[head_count[1:0]] = data_byte;
      head_count_next = head_count + 3'd1;
    end
  end

  assign nonempty_next = (head_count_next != 3'd0);

  always_comb begin
    bom_next = ENC_UNKNOWN;
    if (head_count_next >= 3'd3 && head_bytes_next[0] == BomUtf8B0 &&
        head_bytes_next[1] == BomUtf8B1 && head_bytes_next[2] == BomUtf8B2) begin
      bom_next = ENC_UTF8_BOM;
    end else if (head_count_next >= 3'd4 && head_bytes_next[0] == BomFF &&
                 head_bytes_next[1] == BomFE && head_bytes_next[2] == BomZero &&
                 head_bytes_next[3] == BomZero) begin
      bom_next = ENC_UTF32LE;
    end else if (head_count_next >= 3'd4 && head_bytes_next[0] == BomZero &&
                 head_bytes_next[1] == BomZero && head_bytes_next[2] == BomFE &&
                 head_bytes_next[3] == BomFF) begin
      bom_next = ENC_UTF32BE;
    end else if (head_count_next >= 3'd2 && head_bytes_next[0] == BomFF &&
                 head_bytes_next[1] == BomFE) begin
      bom_next = ENC_UTF16LE;
    end else if (head_count_next >= 3'd2 && head_bytes_next[0] == BomFE &&
                 head_bytes_next[1] == BomFF) begin
      bom_next = ENC_UTF16BE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      head_count <= 3'd0;
    end else if (step) begin
      head_count <= head_count_next;
    end
  end

  // Bytes beyond the fill count are never matched
  always_ff @(posedge clk) begin
    if (step) begin
      head_bytes <= head_bytes_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/ted_utf8.sv
// Strict UTF-8 validator with a saturating score of multibyte bytes.
// Depends on ted_pkg.
`default_nettype none

module ted_utf8 #(
  parameter int SCORE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic                   take,
  input  wire logic                   clear,
  input  wire logic [7:0]             data_byte,
  output logic                        ok_next,
  output logic [SCORE_WIDTH-1:0]      score_next
);
  import ted_pkg::*;

  logic [1:0]             pending, pending_next;
  u8_class_t              cls, cls_next;
  logic                   failed, failed_next;
  logic [SCORE_WIDTH-1:0] score;
  logic                   inc;
  logic                   cont_ok;

  always_comb begin
    case (cls)
      U8C_A0BF: cont_ok = in_range(data_byte, 8'hA0, 8'hBF);
      U8C_809F: cont_ok = in_range(data_byte, 8'h80, 8'h9F);
      U8C_90BF: cont_ok = in_range(data_byte, 8'h90, 8'hBF);
      U8C_808F: cont_ok = in_range(data_byte, 8'h80, 8'h8F);
      default:  cont_ok = in_range(data_byte, 8'h80, 8'hBF);
    endcase
  end

  always_comb begin
    pending_next = pending;
    cls_next     = cls;
    failed_next  = failed;
    inc          = 1'b0;
    if (take && !failed) begin
      if (pending != 2'd0) begin
        if (!cont_ok) begin
          failed_next = 1'b1;
        end else begin
          cls_next     = U8C_ANY;
          pending_next = pending - 2'd1;
          inc          = 1'b1;
        end
      end else if (data_byte[7]) begin
        inc = 1'b1;
        if (in_range(data_byte, 8'hC2, 8'hDF)) begin
          pending_next = 2'd1; cls_next = U8C_ANY;
        end else if (data_byte == 8'hE0) begin
          pending_next = 2'd2; cls_next = U8C_A0BF;
        end else if (data_byte == 8'hED) begin
          pending_next = 2'd2; cls_next = U8C_809F;
        end else if (in_range(data_byte, 8'hE1, 8'hEF)) begin
          pending_next = 2'd2; cls_next = U8C_ANY;
        end else if (data_byte == 8'hF0) begin
          pending_next = 2'd3; cls_next = U8C_90BF;
        end else if (in_range(data_byte, 8'hF1, 8'hF3)) begin
          pending_next = 2'd3; cls_next = U8C_ANY;
        end else if (data_byte == 8'hF4) begin
          pending_next = 2'd3; cls_next = U8C_808F;
        end else begin
          failed_next = 1'b1;
          inc         = 1'b0;
        end
      end
    end
  end

  // Saturating count
  assign score_next = (inc && score != {SCORE_WIDTH{1'b1}}) ?
                      score + SCORE_WIDTH'(1) : score;
  assign ok_next    = !failed_next && (pending_next == 2'd0);

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      pending <= 2'd0;
      cls     <= U8C_ANY;
      failed  <= 1'b0;
      score   <= '0;
    end else if (step) begin
      pending <= pending_next;
      cls     <= cls_next;
      failed  <= failed_next;
      score   <= score_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/ted_sjis.sv
// Shift-JIS validator with a saturating score of half-width kana bytes.
// Depends on ted_pkg.
`default_nettype none

module ted_sjis #(
  parameter int SCORE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic                   take,
  input  wire logic                   clear,
  input  wire logic [7:0]             data_byte,
  output logic                        ok_next,
  output logic [SCORE_WIDTH-1:0]      score_next
);
  import ted_pkg::*;

  logic                   lead_seen, lead_seen_next;
  logic                   failed, failed_next;
  logic [SCORE_WIDTH-1:0] score;
  logic                   inc;

  always_comb begin
    lead_seen_next = lead_seen;
    failed_next    = failed;
    inc            = 1'b0;
    if (take && !failed) begin
      if (lead_seen) begin
        lead_seen_next = 1'b0;
        if (!(in_range(data_byte, 8'h40, 8'h7E) || in_range(data_byte, 8'h80, 8'hFC))) begin
          failed_next = 1'b1;
        end
      end else if (data_byte[7]) begin
        if (in_range(data_byte, 8'hA1, 8'hDF)) begin
          inc = 1'b1;
        end else if (in_range(data_byte, 8'h81, 8'h9F) ||
                     in_range(data_byte, 8'hE0, 8'hFC)) begin
          lead_seen_next = 1'b1;
        end else begin
          failed_next = 1'b1;
        end
      end
    end
  end

  assign score_next = (inc && score != {SCORE_WIDTH{1'b1}}) ?
                      score + SCORE_WIDTH'(1) : score;
  assign ok_next    = !failed_next && !lead_seen_next;

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      lead_seen <= 1'b0;
      failed    <= 1'b0;
      score     <= '0;
    end else if (step) begin
      lead_seen <= lead_seen_next;
      failed    <= failed_next;
      score     <= score_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/text_encoding_detector.sv
// Top level of the text encoding detector: stream ports, input and result registers.
// Depends on ted_pkg, ted_head, ted_utf8 and ted_sjis.
`default_nettype none

// Text encoding detector. Feed a buffer one byte per item on the s_ side; the item
// with s_tlast high ends the buffer and, once it leaves the input register, the block
// offers one encoding code on the m_ side: a byte-order mark among the first four bytes wins
// (UTF-8, UTF-32LE, UTF-32BE, UTF-16LE, UTF-16BE, checked in that order); without
// a mark, a strict UTF-8 checker and a Shift-JIS checker run in parallel and the
// one that did not fail wins, the higher score winning when both pass and UTF-8
// taking ties. A buffer with no byte gives unknown. An item with s_tuser low
// carries no byte and only serves as a bare end marker when s_tlast is high.
// Throughput is one item per clock unless the input stalls: each item is registered,
// then its checker updates and the final decision settle into the state and result
// registers. The result register loads as the last item leaves the input register,
// and m_tvalid is set by that same load. The input stalls only while a finished
// result waits in the output register and another last item needs it.
module text_encoding_detector #(
  parameter int SCORE_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tuser,   // [0] byte_present
  input  wire logic       s_tlast,   // last_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [2:0] encoding, [7:3] zero
);
  import ted_pkg::*;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_present;
  logic       in_last;

  // Result register
  enc_t       res;

  logic       out_free;
  logic       step;
  logic       take;

  enc_t                   bom_next;
  logic                   nonempty_next;
  logic                   u8_ok, sj_ok;
  logic [SCORE_WIDTH-1:0] u8_score, sj_score;
  enc_t                   decision;

  // Advance the held item unless it ends a buffer and the result slot is full
  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && (!in_last || out_free);
  assign take     = step && in_present;
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte    <= s_tdata;
      in_present <= s_tuser;
      in_last    <= s_tlast;
    end
  end

  ted_head u_head (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .take          (take),
    .clear         (in_last),
    .data_byte     (in_byte),
    .bom_next      (bom_next),
    .nonempty_next (nonempty_next)
  );

  ted_utf8 #(.SCORE_WIDTH(SCORE_WIDTH)) u_utf8 (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .take       (take),
    .clear      (in_last),
    .data_byte  (in_byte),
    .ok_next    (u8_ok),
    .score_next (u8_score)
  );

  ted_sjis #(.SCORE_WIDTH(SCORE_WIDTH)) u_sjis (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .take       (take),
    .clear      (in_last),
    .data_byte  (in_byte),
    .ok_next    (sj_ok),
    .score_next (sj_score)
  );

  // Decide from the state as it stands after the current byte
  always_comb begin
    if (!nonempty_next) begin
      decision = ENC_UNKNOWN;
    end else if (bom_next != ENC_UNKNOWN) begin
      decision = bom_next;
    end else if (u8_ok && sj_ok) begin
      decision = (sj_score > u8_score) ? ENC_SJIS : ENC_UTF8;
    end else if (u8_ok) begin
      decision = ENC_UTF8;
    end else if (sj_ok) begin
      decision = ENC_SJIS;
    end else begin
      decision = ENC_UNKNOWN;
    end
  end

  // Result register: load on a last item, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      res <= decision;
    end
  end

  assign m_tdata = {5'd0, res};

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for text_encoding_detector: byte streams in, encoding codes out.
// Depends on ted_pkg and the detector RTL; needs no files or arguments.

module testbench;
  import ted_pkg::*;

  // Narrow scores so a few hundred bytes drive them into saturation
  localparam int ScoreWidth = 8;
  localparam int DirRows = 25;
  localparam int PhaseItems = 400;
  localparam int DrainCycles = 10;
  localparam int HoldOffCycles = 80;
  localparam int RunLimitNs = 3000000;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] data_byte
  logic       s_tuser;   // [0] byte_present
  logic       s_tlast;   // last_byte
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [2:0] encoding, [7:3] zero

  text_encoding_detector #(.SCORE_WIDTH(ScoreWidth)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Scanner state of the bench's own detector copy
  logic [7:0]            head_seen [HeadDepth];
  int                    head_len;
  int                    u8_left;
  u8_class_t             u8_cls;
  logic                  u8_bad;
  logic [ScoreWidth-1:0] u8_score;
  logic                  sj_lead;
  logic                  sj_bad;
  logic [ScoreWidth-1:0] sj_score;

  enc_t       enc_expected [$];  // encodings owed by the block, oldest first
  logic [7:0] text_q [$];        // bytes of the buffer being built
  int         fault_count = 0;
  int         sent_items = 0;
  int         src_idle_pct = 0;
  int         dst_stall_pct = 0;
  int         hold_cycles = 0;

  // Directed rows: a typed encoding where it is obvious, otherwise the scanner decides
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       typed;
    enc_t       want;
  } dir_row_t;

  dir_row_t dir_table [DirRows] = '{
    // bare marker inside a buffer: ignored
    '{8'h5A, 1'b0, 1'b0, 1'b0, ENC_UNKNOWN},
    // empty buffer right after reset
    '{8'hFF, 1'b0, 1'b1, 1'b1, ENC_UNKNOWN},
    // UTF-8 mark
    '{8'hEF, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'hBB, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'hBF, 1'b1, 1'b1, 1'b1, ENC_UTF8_BOM},
    // UTF-32LE mark, must win over the UTF-16LE prefix
    '{8'hFF, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'hFE, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'h00, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'h00, 1'b1, 1'b1, 1'b1, ENC_UTF32LE},
    // UTF-32BE mark
    '{8'h00, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'h00, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'hFE, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'hFF, 1'b1, 1'b1, 1'b1, ENC_UTF32BE},
    // UTF-16LE mark closed by a bare end marker
    '{8'hFF, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'hFE, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'h00, 1'b0, 1'b1, 1'b1, ENC_UTF16LE},
    // UTF-16BE mark
    '{8'hFE, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'hFF, 1'b1, 1'b1, 1'b1, ENC_UTF16BE},
    // lone half-width kana
    '{8'hA1, 1'b1, 1'b1, 1'b0, ENC_UNKNOWN},
    // truncated 3-byte UTF-8 that is a complete Shift-JIS pair
    '{8'hE3, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'h81, 1'b1, 1'b1, 1'b0, ENC_UNKNOWN},
    // F4 takes only 80-8F next; Shift-JIS accepts the pair
    '{8'hF4, 1'b1, 1'b0, 1'b0, ENC_UNKNOWN},
    '{8'h90, 1'b1, 1'b1, 1'b0, ENC_UNKNOWN},
    // single NUL: both pass with zero scores
    '{8'h00, 1'b1, 1'b1, 1'b0, ENC_UNKNOWN},
    // 80 is invalid in both
    '{8'h80, 1'b1, 1'b1, 1'b1, ENC_UNKNOWN}
  };

  function automatic logic [7:0] rand_byte(input int lo, input int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [ScoreWidth-1:0] bump(input logic [ScoreWidth-1:0] s);
    return (s == '1) ? s : s + 1'b1;
  endfunction

  function automatic void clear_scan();
    foreach (head_seen[i]) head_seen[i] = 8'h00;
    head_len = 0;
    u8_left  = 0;
    u8_cls   = U8C_ANY;
    u8_bad   = 1'b0;
    u8_score = '0;
    sj_lead  = 1'b0;
    sj_bad   = 1'b0;
    sj_score = '0;
  endfunction

  // Advance both validators and the head capture by one byte
  function automatic void scan_byte(input logic [7:0] b);
    logic ok;
    if (head_len < HeadDepth) begin
      head_seen[head_len] = b;
      head_len++;
    end
    if (!u8_bad) begin
      if (u8_left != 0) begin
        case (u8_cls)
          U8C_A0BF: ok = (b >= 8'hA0) && (b <= 8'hBF);
          U8C_809F: ok = (b >= 8'h80) && (b <= 8'h9F);
          U8C_90BF: ok = (b >= 8'h90) && (b <= 8'hBF);
          U8C_808F: ok = (b >= 8'h80) && (b <= 8'h8F);
          default:  ok = (b >= 8'h80) && (b <= 8'hBF);
        endcase
        if (!ok) begin
          u8_bad = 1'b1;
        end else begin
          u8_cls = U8C_ANY;
          u8_left--;
          u8_score = bump(u8_score);
        end
      end else if (b >= 8'h80) begin
        if (b >= 8'hC2 && b <= 8'hDF) begin
          u8_left = 1; u8_cls = U8C_ANY;
        end else if (b == 8'hE0) begin
          u8_left = 2; u8_cls = U8C_A0BF;
        end else if (b == 8'hED) begin
          u8_left = 2; u8_cls = U8C_809F;
        end else if (b >= 8'hE1 && b <= 8'hEF) begin
          u8_left = 2; u8_cls = U8C_ANY;
        end else if (b == 8'hF0) begin
          u8_left = 3; u8_cls = U8C_90BF;
        end else if (b >= 8'hF1 && b <= 8'hF3) begin
          u8_left = 3; u8_cls = U8C_ANY;
        end else if (b == 8'hF4) begin
          u8_left = 3; u8_cls = U8C_808F;
        end else begin
          u8_bad = 1'b1;
        end
        if (!u8_bad) u8_score = bump(u8_score);
      end
    end
    if (!sj_bad) begin
      if (sj_lead) begin
        // the byte after a lead is its trail, whatever it looks like
        sj_lead = 1'b0;
        if (!((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC))) sj_bad = 1'b1;
      end else if (b >= 8'h80) begin
        if (b >= 8'hA1 && b <= 8'hDF) sj_score = bump(sj_score);
        else if ((b >= 8'h81 && b <= 8'h9F) || b >= 8'hE0 && b <= 8'hFC) sj_lead = 1'b1;
        else sj_bad = 1'b1;
      end
    end
  endfunction

  function automatic enc_t predict_encoding();
    logic u8_ok;
    logic sj_ok;
    if (head_len == 0) return ENC_UNKNOWN;
    if (head_len >= 3 && head_seen[0] == BomUtf8B0 && head_seen[1] == BomUtf8B1 &&
        head_seen[2] == BomUtf8B2) return ENC_UTF8_BOM;
    if (head_len >= 4 && head_seen[0] == BomFF && head_seen[1] == BomFE &&
        head_seen[2] == BomZero && head_seen[3] == BomZero) return ENC_UTF32LE;
    if (head_len >= 4 && head_seen[0] == BomZero && head_seen[1] == BomZero &&
        head_seen[2] == BomFE && head_seen[3] == BomFF) return ENC_UTF32BE;
    if (head_len >= 2 && head_seen[0] == BomFF && head_seen[1] == BomFE) return ENC_UTF16LE;
    if (head_len >= 2 && head_seen[0] == BomFE && head_seen[1] == BomFF) return ENC_UTF16BE;
    u8_ok = !u8_bad && (u8_left == 0);
    sj_ok = !sj_bad && !sj_lead;
    // UTF-8 keeps ties
    if (u8_ok && sj_ok) return (sj_score > u8_score) ? ENC_SJIS : ENC_UTF8;
    if (u8_ok) return ENC_UTF8;
    if (sj_ok) return ENC_SJIS;
    return ENC_UNKNOWN;
  endfunction

  // Offer one item, idling first as the phase asks; on acceptance update the
  // scanner and, on a last item, queue the encoding it owes
  task automatic drive_item(input logic [7:0] b, input logic present, input logic last,
                            input logic typed, input enc_t want);
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= present;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (present || last) sent_items++;
    if (present) scan_byte(b);
    if (last) begin
      enc_expected.push_back(typed ? want : predict_encoding());
      clear_scan();
    end
  endtask

  // Drop valid and hold until every owed encoding has come back
  task automatic pause_sender();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (enc_expected.size() != 0) @(posedge clk);
  endtask

  // Send text_q as one buffer, with stray bare markers and sometimes a bare end
  task automatic send_text();
    logic bare_end;
    bare_end = (text_q.size() == 0) || ($urandom_range(4) == 0);
    foreach (text_q[i]) begin
      if ($urandom_range(19) == 0) drive_item(rand_byte(0, 255), 1'b0, 1'b0, 1'b0, ENC_UNKNOWN);
      drive_item(text_q[i], 1'b1, !bare_end && (i == text_q.size() - 1), 1'b0, ENC_UNKNOWN);
    end
    if (bare_end) drive_item(rand_byte(0, 255), 1'b0, 1'b1, 1'b0, ENC_UNKNOWN);
    text_q.delete();
  endtask

  task automatic put_utf8_char();
    logic [7:0] lead;
    case ($urandom_range(4))
      1: begin
        text_q.push_back(rand_byte(8'hC2, 8'hDF));
        text_q.push_back(rand_byte(8'h80, 8'hBF));
      end
      2: begin
        lead = rand_byte(8'hE0, 8'hEF);
        text_q.push_back(lead);
        if (lead == 8'hE0) text_q.push_back(rand_byte(8'hA0, 8'hBF));
        else if (lead == 8'hED) text_q.push_back(rand_byte(8'h80, 8'h9F));
        else text_q.push_back(rand_byte(8'h80, 8'hBF));
        text_q.push_back(rand_byte(8'h80, 8'hBF));
      end
      3: begin
        lead = rand_byte(8'hF0, 8'hF4);
        text_q.push_back(lead);
        if (lead == 8'hF0) text_q.push_back(rand_byte(8'h90, 8'hBF));
        else if (lead == 8'hF4) text_q.push_back(rand_byte(8'h80, 8'h8F));
        else text_q.push_back(rand_byte(8'h80, 8'hBF));
        text_q.push_back(rand_byte(8'h80, 8'hBF));
        text_q.push_back(rand_byte(8'h80, 8'hBF));
      end
      default: text_q.push_back(rand_byte(8'h00, 8'h7F));
    endcase
  endtask

  task automatic put_sjis_char();
    case ($urandom_range(3))
      1: text_q.push_back(rand_byte(8'hA1, 8'hDF));
      2: begin
        if ($urandom_range(1) == 0) text_q.push_back(rand_byte(8'h81, 8'h9F));
        else text_q.push_back(rand_byte(8'hE0, 8'hFC));
        if ($urandom_range(1) == 0) text_q.push_back(rand_byte(8'h40, 8'h7E));
        else text_q.push_back(rand_byte(8'h80, 8'hFC));
      end
      default: text_q.push_back(rand_byte(8'h00, 8'h7F));
    endcase
  endtask

  // Two-byte UTF-8 whose bytes are both kana: valid and scored in both
  task automatic put_shared_char();
    if ($urandom_range(2) == 0) begin
      text_q.push_back(rand_byte(8'h00, 8'h7F));
    end else begin
      text_q.push_back(rand_byte(8'hC2, 8'hDF));
      text_q.push_back(rand_byte(8'hA1, 8'hBF));
    end
  endtask

  // Full and partial byte-order marks
  task automatic put_mark();
    case ($urandom_range(7))
      0: begin text_q.push_back(8'hEF); text_q.push_back(8'hBB); text_q.push_back(8'hBF); end
      1: begin
        text_q.push_back(8'hFF); text_q.push_back(8'hFE);
        text_q.push_back(8'h00); text_q.push_back(8'h00);
      end
      2: begin
        text_q.push_back(8'h00); text_q.push_back(8'h00);
        text_q.push_back(8'hFE); text_q.push_back(8'hFF);
      end
      3: begin text_q.push_back(8'hFF); text_q.push_back(8'hFE); end
      4: begin text_q.push_back(8'hFE); text_q.push_back(8'hFF); end
      5: begin text_q.push_back(8'hEF); text_q.push_back(8'hBB); end
      6: begin text_q.push_back(8'hFF); text_q.push_back(8'hFE); text_q.push_back(8'h00); end
      default: begin text_q.push_back(8'h00); text_q.push_back(8'h00); text_q.push_back(8'hFE); end
    endcase
  endtask

  task automatic send_random_buffer();
    int kind;
    int chars;
    kind  = $urandom_range(99);
    chars = $urandom_range(8, 1);
    if (kind < 35) begin
      repeat (chars) put_utf8_char();
    end else if (kind < 60) begin
      repeat (chars) put_sjis_char();
    end else if (kind < 70) begin
      put_mark();
      repeat ($urandom_range(3)) text_q.push_back(rand_byte(0, 255));
    end else if (kind < 85) begin
      repeat (chars) text_q.push_back(rand_byte(0, 255));
    end else if (kind < 94) begin
      repeat (chars) put_shared_char();
    end
    // leave the rest empty; break some well-formed text
    if (kind < 60 || (kind >= 85 && kind < 94)) begin
      if (text_q.size() != 0 && $urandom_range(9) == 0)
        text_q[$urandom_range(text_q.size() - 1)] = rand_byte(0, 255);
      if (text_q.size() != 0 && $urandom_range(9) == 0) void'(text_q.pop_back());
    end
    send_text();
  endtask

  // Long buffer that saturates the scores. Lopsided text gives UTF-8 three
  // points per character and Shift-JIS one, so a score that wraps shows up.
  task automatic send_long_buffer(input logic lopsided);
    repeat ($urandom_range(100, 90)) begin
      if (lopsided) begin
        text_q.push_back(rand_byte(8'hE1, 8'hEC));
        text_q.push_back(rand_byte(8'hA1, 8'hBF));
        text_q.push_back(rand_byte(8'hA1, 8'hBF));
      end else begin
        text_q.push_back(rand_byte(8'hC2, 8'hDF));
        text_q.push_back(rand_byte(8'hA1, 8'hBF));
      end
    end
    send_text();
  endtask

  // Result side: stall at the phase rate, or hold off entirely while a
  // hold-off count is pending
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= dst_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest owed encoding
  always @(posedge clk) begin
    enc_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (enc_expected.size() == 0) begin
        $error("encoding: none expected, got %0d", m_tdata[2:0]);
        fault_count++;
      end else begin
        want = enc_expected.pop_front();
        if (m_tdata[2:0] !== want) begin
          $error("encoding: expected %0d, got %0d", want, m_tdata[2:0]);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #(RunLimitNs);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int idle_plan [4];
    int stall_plan [4];
    int phase_end;
    idle_plan  = '{0, 75, 0, 14};
    stall_plan = '{0, 0, 75, 14};
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    clear_scan();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i])
      drive_item(dir_table[i].data, dir_table[i].present, dir_table[i].last,
                 dir_table[i].typed, dir_table[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = idle_plan[ph];
      dst_stall_pct = stall_plan[ph];
      phase_end = sent_items + PhaseItems;
      if (ph == 0) begin
        // Hold the result side off while one-byte buffers keep coming, so the
        // result register fills and the input stalls; then let it all drain
        hold_cycles = HoldOffCycles;
        repeat (12) drive_item(rand_byte(0, 255), 1'b1, 1'b1, 1'b0, ENC_UNKNOWN);
        pause_sender();
      end
      if (ph == 0 || ph == 2) send_long_buffer(ph == 0);
      while (sent_items < phase_end) send_random_buffer();
    end

    pause_sender();
    repeat (DrainCycles) @(posedge clk);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: text_encoding_detector.f
design/ted_pkg.sv
design/ted_head.sv
design/ted_utf8.sv
design/ted_sjis.sv
design/text_encoding_detector.sv
bench/testbench.sv
